FILE: sv/assert_macros.svh
// assertion macros used by the port checker
// no dependencies; included by files that hold concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle -> consequent holds in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port check failed");

// antecedent holds in a cycle -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

FILE: sv/a2p_pkg.sv
// types and constants of the atan2 polynomial angle block
// no dependencies; imported by the top level, its port checker and the bench
`timescale 1ns / 1ps

package a2p_pkg;

  localparam int ANGLE_W = 16;  // width of the angle result
  localparam int POLY_W  = 13;  // polynomial result, 0..4501

  // polynomial coefficients, z(z(z(C4*z - C3) - C2) + C1)
  localparam int C4 = 829;
  localparam int C3 = 2011;
  localparam int C2 = 58;
  localparam int C1 = 5741;

  localparam logic signed [ANGLE_W-1:0] ANG_90  = 16'sd9000;
  localparam logic signed [ANGLE_W-1:0] ANG_180 = 16'sd18000;

  // per-item sideband that travels with the divider and polynomial stages
  typedef struct packed {
    logic                        both_zero;
    logic                        special;      // x or y is zero, angle is fixed
    logic                        octant_lo;    // |y| < |x|
    logic                        x_neg;
    logic                        y_neg;
    logic signed [ANGLE_W-1:0]   fixed_angle;  // angle used when special
  } side_t;

  typedef struct packed {
    logic                        both_zero;
    logic signed [ANGLE_W-1:0]   angle;
  } result_t;

endpackage

FILE: sv/atan2_poly_centidegrees.sv
// atan2 of a signed vector in hundredths of a degree, pipelined divider and polynomial
// depends on a2p_pkg
`timescale 1ns / 1ps

// usage
//   slave channel: one (y_in, x_in) pair per transfer, y_in in the low INPUT_WIDTH bits
//   of s_axis_tdata_i and x_in just above it, both two's complement
//   master channel: m_axis_tdata_o carries the angle, -18000..18000, in two's complement;
//   m_axis_tuser_o[0] is set when x and y are both zero, the angle is then 0
//   pipeline from an input transfer to tvalid of its result: one input stage,
//   FRAC_BITS+1 restoring divider stages at one quotient bit each, six
//   polynomial stages (three multiplies, each after its add stage) and the
//   output register
//   throughput: one pair per cycle while s_axis_tready_o is high; every stage holds one item
//   stall: when the receiver drops tready, the waiting result stays in the output
//   register and one more result is caught in a skid register; only when the skid
//   register is full does s_axis_tready_o fall and the whole pipeline freeze,
//   so nothing is dropped or repeated and ready returns the cycle after tready
//   reset: all valid bits clear, the block is ready to take a pair when
//   rst_ni rises; the block keeps no state between items
module atan2_poly_centidegrees #(
  parameter int INPUT_WIDTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [((2*INPUT_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,   // y_in, x_in, zero fill
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [a2p_pkg::ANGLE_W-1:0]            m_axis_tdata_o,   // angle_centideg
  output logic [0:0]                             m_axis_tuser_o    // both_zero
);
  import a2p_pkg::*;

  localparam int W   = INPUT_WIDTH;
  localparam int ZW  = FRAC_BITS + 1;    // ratio z, 0..1.0
  localparam int M1W = FRAC_BITS + 11;   // |t1| <= 2011 * 2^F
  localparam int M2W = FRAC_BITS + 12;   // |t2| < 2069 * 2^F
  localparam int T3W = FRAC_BITS + 13;   // t3 <= 5741 * 2^F
  localparam int P1W = M1W + ZW;
  localparam int P2W = M2W + ZW;
  localparam int P3W = T3W + ZW;

  // whole pipeline advances unless the skid register holds a result
  logic en;

  // ---------------------------------------------------------------------------
  // input decode: magnitudes, octant and the fixed angles of the axis cases
  // ---------------------------------------------------------------------------
  logic [W-1:0] y_in, x_in, ay, ax, lo, hi;
  logic         y_zero, x_zero, octant_lo;
  side_t        in_side;

  always_comb begin
    y_in      = s_axis_tdata_i[W-1:0];
    x_in      = s_axis_tdata_i[2*W-1:W];
    ay        = y_in[W-1] ? (~y_in + W'(1)) : y_in;
    ax        = x_in[W-1] ? (~x_in + W'(1)) : x_in;
    y_zero    = (y_in == '0);
    x_zero    = (x_in == '0);
    octant_lo = (ay < ax);
    lo        = octant_lo ? ay : ax;
    hi        = octant_lo ? ax : ay;

    in_side.both_zero = x_zero && y_zero;
    in_side.special   = x_zero || y_zero;
    in_side.octant_lo = octant_lo;
    in_side.x_neg     = x_in[W-1];
    in_side.y_neg     = y_in[W-1];
    if (x_zero && y_zero) begin
      in_side.fixed_angle = '0;
    end else if (x_zero) begin
      in_side.fixed_angle = y_in[W-1] ? -ANG_90 : ANG_90;
    end else if (x_in[W-1]) begin
      in_side.fixed_angle = ANG_180;   // y zero, x negative
    end else begin
      in_side.fixed_angle = '0;        // y zero, x positive
    end
  end

  // ---------------------------------------------------------------------------
  // restoring divider, z = (lo << FRAC_BITS) / hi, one quotient bit per stage
  // index 0 is the input register, index ZW holds the full quotient
  // ---------------------------------------------------------------------------
  logic          dv_q   [ZW+1];
  logic [W:0]    drem_q [ZW+1];
  logic [W-1:0]  dhi_q  [ZW+1];
  logic [ZW-1:0] dquo_q [ZW+1];
  side_t         dside_q[ZW+1];

  logic [W:0]    drem_d [ZW+1];
  logic [ZW-1:0] dquo_d [ZW+1];

  always_comb begin
    logic          ge;
    logic [W:0]    diff;
    logic [W:0]    sel;
    drem_d[0] = {1'b0, lo};
    dquo_d[0] = '0;
    for (int k = 1; k <= ZW; k++) begin
      ge        = (drem_q[k-1] >= {1'b0, dhi_q[k-1]});
      diff      = drem_q[k-1] - {1'b0, dhi_q[k-1]};
      sel       = ge ? diff : drem_q[k-1];
      drem_d[k] = {sel[W-1:0], 1'b0};
      dquo_d[k] = {dquo_q[k-1][ZW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= ZW; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else if (en) begin
      dv_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k <= ZW; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      drem_q[0]  <= drem_d[0];
      dhi_q[0]   <= hi;
      dquo_q[0]  <= dquo_d[0];
      dside_q[0] <= in_side;
      for (int k = 1; k <= ZW; k++) begin
        drem_q[k]  <= drem_d[k];
        dhi_q[k]   <= dhi_q[k-1];
        dquo_q[k]  <= dquo_d[k];
        dside_q[k] <= dside_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // polynomial, a = z(z(z(829z - 2011) - 58) + 5741) in fixed point
  // t1 and t2 are always negative on 0 <= z <= 1, so their magnitudes are kept
  // and truncation toward zero becomes a plain right shift
  // ---------------------------------------------------------------------------
  logic           v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  side_t          s1_q, s2_q, s3_q, s4_q, s5_q, s6_q;
  logic [ZW-1:0]  z1_q, z2_q, z3_q, z4_q, z5_q;
  logic [M1W-1:0] m1_d, m1_q;       // -t1
  logic [P1W-1:0] prod1_d, prod1_q;
  logic [M2W-1:0] m2_d, m2_q;       // -t2
  logic [P2W-1:0] prod2_d, prod2_q;
  logic [T3W-1:0] t3_d, t3_q;
  logic [P3W-1:0] prod3_d, prod3_q;

  always_comb begin
    m1_d    = (M1W'(C3) << FRAC_BITS) - M1W'(dquo_q[ZW]) * M1W'(C4);
    prod1_d = P1W'(m1_q) * P1W'(z1_q);
    m2_d    = M2W'(prod1_q >> FRAC_BITS) + (M2W'(C2) << FRAC_BITS);
    prod2_d = P2W'(m2_q) * P2W'(z3_q);
    t3_d    = (T3W'(C1) << FRAC_BITS) - T3W'(prod2_q >> FRAC_BITS);
    prod3_d = P3W'(t3_q) * P3W'(z5_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= dv_q[ZW];
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q    <= dside_q[ZW];
      z1_q    <= dquo_q[ZW];
      m1_q    <= m1_d;
      s2_q    <= s1_q;
      z2_q    <= z1_q;
      prod1_q <= prod1_d;
      s3_q    <= s2_q;
      z3_q    <= z2_q;
      m2_q    <= m2_d;
      s4_q    <= s3_q;
      z4_q    <= z3_q;
      prod2_q <= prod2_d;
      s5_q    <= s4_q;
      z5_q    <= z4_q;
      t3_q    <= t3_d;
      s6_q    <= s5_q;
      prod3_q <= prod3_d;
    end
  end

  // ---------------------------------------------------------------------------
  // octant mapping of the first-octant angle to the full circle
  // ---------------------------------------------------------------------------
  logic [POLY_W-1:0]         a_u;
  logic signed [ANGLE_W-1:0] a_s;
  result_t                   res;

  always_comb begin
    a_u           = prod3_q[2*FRAC_BITS +: POLY_W];
    a_s           = signed'({{(ANGLE_W-POLY_W){1'b0}}, a_u});
    res.both_zero = s6_q.both_zero;
    if (s6_q.special) begin
      res.angle = s6_q.fixed_angle;
    end else if (s6_q.octant_lo) begin
      if (!s6_q.x_neg) begin
        res.angle = s6_q.y_neg ? -a_s : a_s;
      end else begin
        res.angle = s6_q.y_neg ? (a_s - ANG_180) : (ANG_180 - a_s);
      end
    end else begin
      if (!s6_q.x_neg) begin
        res.angle = s6_q.y_neg ? (a_s - ANG_90) : (ANG_90 - a_s);
      end else begin
        res.angle = s6_q.y_neg ? (-a_s - ANG_90) : (a_s + ANG_90);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register with skid register
  // ---------------------------------------------------------------------------
  logic    push, pop;
  logic    out_v_d, out_v_q, skid_v_d, skid_v_q;
  logic    out_ld, skid_ld;
  result_t out_d, out_q, skid_q;

  always_comb begin
    push     = en && v6_q;
    pop      = out_v_q && m_axis_tready_i;
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_ld   = 1'b0;
    skid_ld  = 1'b0;
    out_d    = res;
    if (skid_v_q) begin
      // pipeline frozen, drain the skid register first
      out_d = skid_q;
      if (pop) begin
        out_ld   = 1'b1;
        skid_v_d = 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_ld  = 1'b1;
        out_v_d = 1'b1;
      end else begin
        skid_ld  = 1'b1;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_q <= out_d;
    end
    if (skid_ld) begin
      skid_q <= res;
    end
  end

  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q.angle;
  assign m_axis_tuser_o  = out_q.both_zero;

endmodule

FILE: sv/a2p_port_chk.sv
// port checker of the atan2 polynomial angle block, bound to the top level
// depends on a2p_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module a2p_port_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [a2p_pkg::ANGLE_W-1:0]   m_axis_tdata_o,
  input logic [0:0]                    m_axis_tuser_o
);
  import a2p_pkg::*;

  // a stalled result keeps its value
  `ASSERT_NEXT(hold_chk, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // zero vector gives angle zero
  `ASSERT_IMPL(zero_chk, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == '0)

  // angle stays within -18000..18000
  `ASSERT_IMPL(range_chk, clk_i, rst_ni, m_axis_tvalid_o, ($signed(m_axis_tdata_o) >= -18000) && ($signed(m_axis_tdata_o) <= 18000))

  // receiver ready always empties the skid register by the next cycle
  `ASSERT_IMPL(ready_chk, clk_i, rst_ni, $past(m_axis_tready_i), s_axis_tready_o)

endmodule

bind atan2_poly_centidegrees a2p_port_chk u_a2p_port_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

FILE: bench/atan2_poly_centidegrees_tb.sv
// self-checking bench for atan2_poly_centidegrees: random and corner (y, x) pairs,
// expected angles from a fixed-point polynomial predictor held in a small scoreboard
// depends on a2p_pkg and the atan2_poly_centidegrees rtl
`timescale 1ns / 1ps

module atan2_poly_centidegrees_tb;

  import a2p_pkg::*;

  localparam int IW          = 16;
  localparam int FB          = 16;
  localparam int LATENCY     = FB + 8;
  localparam int N_RANDOM    = 1350;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_LIMIT  = 3000;

  // expected angles in arrival order, predictor of the polynomial and octant mapping
  class angle_scoreboard;
    result_t expected_angles[$];
    int      mismatches;

    function new();
      mismatches = 0;
    endfunction

    // trunc toward zero of v * z / 2^FB
    function longint frac_mul(longint v, longint z);
      longint mag;
      longint p;
      mag = (v < 0) ? -v : v;
      p   = (mag * z) >> FB;
      return (v < 0) ? -p : p;
    endfunction

    // fourth-order arctangent of z in [0, 1], result in centidegrees 0..4501
    function longint arctan_poly(longint z);
      longint one;
      longint t1;
      longint t2;
      longint t3;
      one = longint'(1) << FB;
      t1  = C4 * z - C3 * one;
      t2  = frac_mul(t1, z) - C2 * one;
      t3  = frac_mul(t2, z) + C1 * one;
      return (t3 * z) >> (2 * FB);
    endfunction

    function result_t predict_angle(logic signed [IW-1:0] y, logic signed [IW-1:0] x);
      result_t r;
      longint  ys;
      longint  xs;
      longint  ay;
      longint  ax;
      longint  z;
      longint  a;
      longint  ang;
      bit      q;
      ys = y;
      xs = x;
      ay = (ys < 0) ? -ys : ys;
      ax = (xs < 0) ? -xs : xs;
      r.both_zero = 1'b0;
      if (xs == 0 && ys == 0) begin
        ang = 0;
        r.both_zero = 1'b1;
      end else if (xs == 0) begin
        ang = (ys > 0) ? 9000 : -9000;
      end else if (ys == 0) begin
        ang = (xs < 0) ? 18000 : 0;
      end else begin
        // ratio of the smaller to the larger magnitude, truncated
        q = (ay < ax);
        z = q ? ((ay << FB) / ax) : ((ax << FB) / ay);
        a = arctan_poly(z);
        if (q) begin
          if (xs > 0) ang = (ys < 0) ? -a : a;
          else        ang = (ys > 0) ? 18000 - a : a - 18000;
        end else begin
          if (xs > 0) ang = (ys > 0) ? 9000 - a : a - 9000;
          else        ang = (ys > 0) ? a + 9000 : -a - 9000;
        end
      end
      r.angle = ang[ANGLE_W-1:0];
      return r;
    endfunction

    function void note_pair(logic signed [IW-1:0] y, logic signed [IW-1:0] x);
      expected_angles.push_back(predict_angle(y, x));
    endfunction

    function void check_result(logic [ANGLE_W-1:0] angle, logic both_zero);
      result_t e;
      if (expected_angles.size() == 0) begin
        $error("unexpected result: angle_centideg %0d both_zero %0b",
               $signed(angle), both_zero);
        mismatches++;
        return;
      end
      e = expected_angles.pop_front();
      if (angle !== e.angle) begin
        $error("angle_centideg mismatch: expected %0d, actual %0d",
               $signed(e.angle), $signed(angle));
        mismatches++;
      end
      if (both_zero !== e.both_zero) begin
        $error("both_zero mismatch: expected %0b, actual %0b", e.both_zero, both_zero);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_valid;
  logic                s_ready;
  logic [2*IW-1:0]     s_data;    // y_in, x_in
  logic                m_valid;
  logic                m_ready;
  logic [ANGLE_W-1:0]  m_data;    // angle_centideg
  logic [0:0]          m_user;    // both_zero

  angle_scoreboard sb = new();

  bit hold_req = 1'b0;   // asks the receiver for one long hold-off
  int tx_free_left = 0;  // transfers still to send back to back
  int idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  atan2_poly_centidegrees #(
    .INPUT_WIDTH(IW),
    .FRAC_BITS  (FB)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  // mostly back to back or short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // monitor: both handshakes and the watchdog, sampled at the rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (s_valid && s_ready) begin
        sb.note_pair(s_data[IW-1:0], s_data[2*IW-1:IW]);
      end
      if (m_valid && m_ready) begin
        sb.check_result(m_data, m_user[0]);
      end
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: random stalls, free-running stretches, one long hold-off on request
  initial begin
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left  = 0;
    m_ready    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready  = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (stall_left > 0) begin
        m_ready = 1'b0;
        stall_left--;
      end else begin
        m_ready = 1'b1;
        if (free_left > 0) begin
          free_left--;
        end else begin
          stall_left = draw_gap();
          if ($urandom_range(0, 149) == 0) free_left = $urandom_range(50, 300);
        end
      end
    end
  end

  // one transfer on the slave side; entered and left at a falling edge
  task automatic send_pair(logic signed [IW-1:0] y, logic signed [IW-1:0] x);
    int gap;
    if (tx_free_left > 0) begin
      tx_free_left--;
      gap = 0;
    end else begin
      gap = draw_gap();
      if ($urandom_range(0, 99) == 0) tx_free_left = $urandom_range(30, 200);
    end
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = {x, y};
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
  endtask

  task automatic send_random_pair();
    logic signed [IW-1:0] y;
    logic signed [IW-1:0] x;
    logic signed [IW-1:0] corners [6];
    int                   r;
    int                   m;
    corners = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    r = $urandom_range(0, 99);
    if (r < 55) begin
      y = IW'($urandom());
      x = IW'($urandom());
    end else if (r < 70) begin
      // tiny magnitudes hit zeros, equal magnitudes and steep ratios
      y = IW'($urandom_range(0, 8) - 4);
      x = IW'($urandom_range(0, 8) - 4);
    end else if (r < 80) begin
      // diagonal, ratio exactly one
      m = $urandom_range(1, 32767);
      y = IW'($urandom_range(0, 1) ? m : -m);
      x = IW'($urandom_range(0, 1) ? m : -m);
    end else if (r < 90) begin
      // on an axis
      if ($urandom_range(0, 1)) begin
        y = '0;
        x = IW'($urandom());
      end else begin
        y = IW'($urandom());
        x = '0;
      end
    end else begin
      y = corners[$urandom_range(0, 5)];
      x = corners[$urandom_range(0, 5)];
    end
    send_pair(y, x);
  endtask

  // stimulus
  initial begin
    s_valid = 1'b0;
    s_data  = '0;
    rst_ni  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // corners: origin, each axis, diagonals of every quadrant, full-scale values
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd5, 16'sd0);
    send_pair(-16'sd5, 16'sd0);
    send_pair(16'sd0, 16'sd5);
    send_pair(16'sd0, -16'sd5);
    send_pair(16'sd0, -16'sd32768);
    send_pair(-16'sd32768, 16'sd0);
    send_pair(16'sd32767, 16'sd0);
    send_pair(16'sd0, 16'sd32767);
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(16'sd32767, -16'sd32768);
    send_pair(16'sd1, -16'sd32768);
    send_pair(-16'sd32768, 16'sd1);
    send_pair(-16'sd1, -16'sd1);
    send_pair(16'sd1, 16'sd1);
    send_pair(16'sd1, -16'sd1);
    send_pair(-16'sd1, 16'sd1);
    send_pair(16'sd100, 16'sd200);
    send_pair(-16'sd200, 16'sd100);
    send_pair(-16'sd3, 16'sd32767);
    send_pair(16'sd32767, -16'sd3);
    send_pair(16'sd12345, -16'sd23456);

    for (int i = 0; i < N_RANDOM; i++) begin
      // long receiver hold-off while the sender keeps offering back to back
      if (i == 300 || i == 900) begin
        hold_req     = 1'b1;
        tx_free_left = 120;
      end
      send_random_pair();
    end
    s_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 16) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
